// ===== design/ddcp_pkg.sv =====
package ddcp_pkg;

  // Field and counter widths
  localparam int BYTE_W      = 8;
  localparam int CODE_W      = 50;
  localparam int CFG_IDX_W   = 2;
  localparam int POS_W       = 8;
  localparam int DIGIT_CNT_W = 5;
  localparam int TDATA_OUT_W = 56;

  // Frame limits
  localparam logic [POS_W-1:0]       MAX_FRAME_LEN = 8'd255;
  localparam logic [POS_W-1:0]       MIN_FRAME_LEN = 8'd3;
  localparam logic [DIGIT_CNT_W-1:0] MAX_DIGITS    = 5'd15;

  // ASCII digit range
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_SEP_BYTE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_END_BYTE = 2'd3;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] START_BYTE_RST    = 8'd123;
  localparam logic [BYTE_W-1:0] END_BYTE_RST      = 8'd125;
  localparam logic [BYTE_W-1:0] CODE_SEP_BYTE_RST = 8'd58;
  localparam logic [BYTE_W-1:0] CODE_END_BYTE_RST = 8'd59;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] code_sep_byte;
    logic [BYTE_W-1:0] code_end_byte;
  } cfg_t;

  // One input word handed from the input register to the scanner
  typedef struct packed {
    logic              fire;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_last;
  } word_t;

  // One frame result handed from the scanner to the output register
  typedef struct packed {
    logic              load;
    logic [CODE_W-1:0] code_value;
    logic              code_valid;
  } result_t;

endpackage

// ===== design/ddcp_cfg_regs.sv =====
module ddcp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ddcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ddcp_pkg::BYTE_W-1:0]    cfg_data,
  output ddcp_pkg::cfg_t                 cfg
);

  // Write one delimiter register per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte    <= ddcp_pkg::START_BYTE_RST;
      cfg.end_byte      <= ddcp_pkg::END_BYTE_RST;
      cfg.code_sep_byte <= ddcp_pkg::CODE_SEP_BYTE_RST;
      cfg.code_end_byte <= ddcp_pkg::CODE_END_BYTE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ddcp_pkg::REG_START_BYTE:    cfg.start_byte    <= cfg_data;
        ddcp_pkg::REG_END_BYTE:      cfg.end_byte      <= cfg_data;
        ddcp_pkg::REG_CODE_SEP_BYTE: cfg.code_sep_byte <= cfg_data;
        ddcp_pkg::REG_CODE_END_BYTE: cfg.code_end_byte <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/ddcp_in_stage.sv =====
module ddcp_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [ddcp_pkg::BYTE_W-1:0] s_tdata,
  input  logic                        s_tlast,
  input  logic                        out_free,
  output ddcp_pkg::word_t             word
);

  logic                        in_valid;
  logic [ddcp_pkg::BYTE_W-1:0] in_byte;
  logic                        in_last;
  logic                        fire;

  // Advance a held word unless it closes a frame and the result slot is full
  assign fire     = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  assign word.fire       = fire;
  assign word.rx_byte    = in_byte;
  assign word.frame_last = in_last;

endmodule

// ===== design/ddcp_frame_scan.sv =====
module ddcp_frame_scan (
  input  logic              clk,
  input  logic              rst,
  input  ddcp_pkg::cfg_t    cfg,
  input  ddcp_pkg::word_t   word,
  output ddcp_pkg::result_t result
);

  logic [ddcp_pkg::POS_W-1:0]       byte_position,    byte_position_next;
  logic [ddcp_pkg::POS_W-1:0]       start_position,   start_position_next;
  logic [ddcp_pkg::POS_W-1:0]       code_begin,       code_begin_next;
  logic                             end_seen,         end_seen_next;
  logic                             code_end_seen,    code_end_seen_next;
  logic [ddcp_pkg::DIGIT_CNT_W-1:0] digit_count,      digit_count_next;
  logic                             bad_char_seen,    bad_char_seen_next;
  logic [ddcp_pkg::CODE_W-1:0]      code_accumulator, code_accumulator_next;
  logic                             frame_ok,         frame_ok_next;

  logic                             scan;
  logic                             in_code;
  logic                             is_digit;
  logic [ddcp_pkg::DIGIT_CNT_W-1:0] count_inc;
  logic [ddcp_pkg::CODE_W-1:0]      digit_ext;
  logic [ddcp_pkg::CODE_W-1:0]      acc_times_ten;
  logic                             ok;

  assign scan     = (byte_position < ddcp_pkg::MAX_FRAME_LEN) && !end_seen;
  assign in_code  = (code_begin != '0) && (byte_position >= code_begin) && !code_end_seen;
  assign is_digit = (word.rx_byte >= ddcp_pkg::CHAR_ZERO) &&
                    (word.rx_byte <= ddcp_pkg::CHAR_NINE);
  assign count_inc = digit_count + 1'b1;
  // The low nibble of an ASCII digit is its value
  assign digit_ext = {{(ddcp_pkg::CODE_W-4){1'b0}}, word.rx_byte[3:0]};
  // Times ten as 8x + 2x
  assign acc_times_ten = {code_accumulator[ddcp_pkg::CODE_W-4:0], 3'b000} +
                         {code_accumulator[ddcp_pkg::CODE_W-2:0], 1'b0};

  // Per-byte update of the frame state
  always_comb begin
    byte_position_next    = byte_position;
    start_position_next   = start_position;
    code_begin_next       = code_begin;
    end_seen_next         = end_seen;
    code_end_seen_next    = code_end_seen;
    digit_count_next      = digit_count;
    bad_char_seen_next    = bad_char_seen;
    code_accumulator_next = code_accumulator;
    frame_ok_next         = frame_ok;

    if (byte_position < ddcp_pkg::MAX_FRAME_LEN) begin
      byte_position_next = byte_position + 1'b1;
    end

    if (scan) begin
      if (word.rx_byte == cfg.end_byte && word.rx_byte != cfg.start_byte) begin
        // End byte: judge the delimiters and stop scanning
        end_seen_next = 1'b1;
        frame_ok_next = (start_position < byte_position) &&
                        (code_begin > start_position) &&
                        (code_begin < byte_position) &&
                        code_end_seen &&
                        (digit_count != '0) &&
                        (digit_count <= ddcp_pkg::MAX_DIGITS) &&
                        !bad_char_seen;
      end else begin
        if (word.rx_byte == cfg.start_byte) begin
          start_position_next = byte_position;
        end else if (word.rx_byte == cfg.code_sep_byte && code_begin == '0) begin
          code_begin_next = byte_position + 1'b1;
        end

        // Code region: terminate, count and accumulate
        if (in_code) begin
          if (word.rx_byte == cfg.code_end_byte) begin
            code_end_seen_next = 1'b1;
          end else if (digit_count <= ddcp_pkg::MAX_DIGITS) begin
            digit_count_next = count_inc;
            if (is_digit) begin
              if (count_inc <= ddcp_pkg::MAX_DIGITS) begin
                code_accumulator_next = acc_times_ten + digit_ext;
              end
            end else begin
              bad_char_seen_next = 1'b1;
            end
          end
        end
      end
    end
  end

  assign ok = frame_ok_next && end_seen_next && (byte_position_next >= ddcp_pkg::MIN_FRAME_LEN);

  // Hold state between words; clear after the final byte of a frame
  always_ff @(posedge clk) begin
    if (rst || (word.fire && word.frame_last)) begin
      byte_position    <= '0;
      start_position   <= '0;
      code_begin       <= '0;
      end_seen         <= 1'b0;
      code_end_seen    <= 1'b0;
      digit_count      <= '0;
      bad_char_seen    <= 1'b0;
      code_accumulator <= '0;
      frame_ok         <= 1'b0;
    end else if (word.fire) begin
      byte_position    <= byte_position_next;
      start_position   <= start_position_next;
      code_begin       <= code_begin_next;
      end_seen         <= end_seen_next;
      code_end_seen    <= code_end_seen_next;
      digit_count      <= digit_count_next;
      bad_char_seen    <= bad_char_seen_next;
      code_accumulator <= code_accumulator_next;
      frame_ok         <= frame_ok_next;
    end
  end

  assign result.load       = word.fire && word.frame_last;
  assign result.code_value = ok ? code_accumulator_next : '0;
  assign result.code_valid = ok;

endmodule

// ===== design/ddcp_out_stage.sv =====
module ddcp_out_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  ddcp_pkg::result_t                result,
  output logic                             out_free,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ddcp_pkg::TDATA_OUT_W-1:0] m_tdata,
  output logic [0:0]                       m_tuser
);

  logic                          out_valid;
  logic [ddcp_pkg::CODE_W-1:0]   out_code;
  logic                          out_ok;

  assign out_free = !out_valid || m_tready;

  // Load a new result or drop the one taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      out_code <= result.code_value;
      out_ok   <= result.code_valid;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(ddcp_pkg::TDATA_OUT_W-ddcp_pkg::CODE_W){1'b0}}, out_code};
  assign m_tuser  = out_ok;

endmodule

// ===== design/delimited_decimal_code_parser_core.sv =====
// Channel  | Direction | Handshake          | Fields (lowest bit up)
// ---------+-----------+--------------------+-----------------------------------
// s_       | in        | s_tvalid/s_tready  | tdata: rx_byte[7:0]; tlast: frame_last
// m_       | out       | m_tvalid/m_tready  | tdata: code_value[49:0]; tuser: code_valid
// cfg_     | in        | cfg_we             | cfg_index[1:0], cfg_data[7:0]
//
// One word is accepted per cycle while the input side is not stalled; a result is
// loaded into the result register when its final word leaves the input register.
// Latency is set by the input register and the result register around the scanner.
// The input side stalls only when a final word meets a result not yet taken.
// Reset (rst, synchronous) restores the delimiter values and clears the frame state.
module delimited_decimal_code_parser_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ddcp_pkg::BYTE_W-1:0]      s_tdata,   // rx_byte[7:0]
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ddcp_pkg::TDATA_OUT_W-1:0] m_tdata,   // code_value[49:0], zero pad
  output logic [0:0]                       m_tuser,   // code_valid[0]
  input  logic                             cfg_we,
  input  logic [ddcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ddcp_pkg::BYTE_W-1:0]      cfg_data
);

  ddcp_pkg::cfg_t    cfg;
  ddcp_pkg::word_t   word;
  ddcp_pkg::result_t result;
  logic              out_free;

  ddcp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ddcp_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .out_free (out_free),
    .word     (word)
  );

  ddcp_frame_scan u_frame_scan (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .word   (word),
    .result (result)
  );

  ddcp_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .result   (result),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== design/ddcp_checker.sv =====
module ddcp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [ddcp_pkg::BYTE_W-1:0]      s_tdata,
  input logic                             s_tlast,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [ddcp_pkg::TDATA_OUT_W-1:0] m_tdata,
  input logic [0:0]                       m_tuser,
  input logic                             cfg_we,
  input logic [ddcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [ddcp_pkg::BYTE_W-1:0]      cfg_data
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

  // A failed frame carries a zero code
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("failed frame with nonzero code");

  // A parsed code has at most fifteen digits
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata < 56'd1000000000000000)
    else $error("parsed code out of range");

  // Input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

endmodule

bind delimited_decimal_code_parser_core ddcp_checker u_checker (.*);

// ===== test/delimited_decimal_code_parser_core_tb.sv =====
module delimited_decimal_code_parser_core_tb;

  // One frame result: parsed code and its valid flag
  typedef struct {
    logic [ddcp_pkg::CODE_W-1:0] value;
    logic                        valid;
  } code_result_t;

  // Ways to stretch a frame past the length limit
  typedef enum int {NO_LONG, LONG_TAIL, LONG_MID} long_kind_e;

  // Receiver stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  // Tracks delimiter positions per frame and holds the codes still owed by the block
  class code_board;
    logic [ddcp_pkg::BYTE_W-1:0]      start_val, end_val, sep_val, term_val;
    logic [ddcp_pkg::POS_W-1:0]       pos, start_mark, code_begin;
    logic [ddcp_pkg::DIGIT_CNT_W-1:0] n_digits;
    logic [ddcp_pkg::CODE_W-1:0]      acc;
    bit                               end_seen, term_seen, bad_char, frame_ok;
    code_result_t                     pending_codes[$];
    int                               errors;

    function new();
      start_val = ddcp_pkg::START_BYTE_RST;
      end_val   = ddcp_pkg::END_BYTE_RST;
      sep_val   = ddcp_pkg::CODE_SEP_BYTE_RST;
      term_val  = ddcp_pkg::CODE_END_BYTE_RST;
      errors    = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      pos        = '0;
      start_mark = '0;
      code_begin = '0;
      n_digits   = '0;
      acc        = '0;
      end_seen   = 1'b0;
      term_seen  = 1'b0;
      bad_char   = 1'b0;
      frame_ok   = 1'b0;
    endfunction

    function void set_reg(logic [ddcp_pkg::CFG_IDX_W-1:0] idx,
                          logic [ddcp_pkg::BYTE_W-1:0] val);
      case (idx)
        ddcp_pkg::REG_START_BYTE:    start_val = val;
        ddcp_pkg::REG_END_BYTE:      end_val   = val;
        ddcp_pkg::REG_CODE_SEP_BYTE: sep_val   = val;
        ddcp_pkg::REG_CODE_END_BYTE: term_val  = val;
        default: ;
      endcase
    endfunction

    // Update delimiter tracking and the code value for one in-range byte
    function void scan_byte(logic [ddcp_pkg::BYTE_W-1:0] b);
      bit in_code;
      in_code = (code_begin != '0) && (pos >= code_begin) && !term_seen;
      if (b == start_val) begin
        start_mark = pos;
      end else if (b == end_val) begin
        end_seen = 1'b1;
        frame_ok = (start_mark < pos) && (code_begin > start_mark) && (code_begin < pos) &&
                   term_seen && (n_digits != '0) && (n_digits <= ddcp_pkg::MAX_DIGITS) &&
                   !bad_char;
        return;
      end else if (b == sep_val && code_begin == '0) begin
        code_begin = pos + 1'b1;
      end
      if (in_code) begin
        if (b == term_val) begin
          term_seen = 1'b1;
        end else if (n_digits <= ddcp_pkg::MAX_DIGITS) begin
          n_digits = n_digits + 1'b1;
          if (b >= ddcp_pkg::CHAR_ZERO && b <= ddcp_pkg::CHAR_NINE) begin
            if (n_digits <= ddcp_pkg::MAX_DIGITS)
              acc = acc * 10 + ddcp_pkg::CODE_W'(b - ddcp_pkg::CHAR_ZERO);
          end else begin
            bad_char = 1'b1;
          end
        end
      end
    endfunction

    // Note one accepted word; a final word owes one code
    function void note_word(logic [ddcp_pkg::BYTE_W-1:0] b, logic last);
      code_result_t r;
      if (pos < ddcp_pkg::MAX_FRAME_LEN) begin
        if (!end_seen) scan_byte(b);
        pos = pos + 1'b1;
      end
      if (last) begin
        r.valid = frame_ok && end_seen && (pos >= ddcp_pkg::MIN_FRAME_LEN);
        r.value = r.valid ? acc : '0;
        pending_codes.push_back(r);
        restart_frame();
      end
    endfunction

    // Compare one accepted result word with the oldest owed code
    function void check_result(logic [ddcp_pkg::CODE_W-1:0] value, logic valid);
      code_result_t r;
      if (pending_codes.size() == 0) begin
        $error("unexpected result: code_value %0d code_valid %0b", value, valid);
        errors++;
        return;
      end
      r = pending_codes.pop_front();
      if (valid !== r.valid) begin
        $error("code_valid: expected %0b actual %0b", r.valid, valid);
        errors++;
      end
      if (value !== r.value) begin
        $error("code_value: expected %0d actual %0d", r.value, value);
        errors++;
      end
    endfunction

    function int pending();
      return pending_codes.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [ddcp_pkg::BYTE_W-1:0]      s_tdata;   // rx_byte[7:0]
  logic                             s_tlast;   // frame_last
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [ddcp_pkg::TDATA_OUT_W-1:0] m_tdata;   // code_value[49:0], zero pad
  logic [0:0]                       m_tuser;   // code_valid[0]
  logic                             cfg_we;
  logic [ddcp_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [ddcp_pkg::BYTE_W-1:0]      cfg_data;

  code_board                   board;
  logic [ddcp_pkg::BYTE_W-1:0] frame_bytes[$];
  int                          burst_left = 0;
  int                          words_sent = 0;
  int                          rx_tick = 0;
  string                       directed_frames[6] =
    '{"{:9;}", "{:;}", "}{", "{:0x;}z", "{:5;", ":1;{}"};

  delimited_decimal_code_parser_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the result side on a rotating pattern
  always @(negedge clk) begin
    rx_tick = rx_tick + 1;
    case (rx_mode_e'((rx_tick / 256) % 4))
      RX_OPEN:     m_tready = 1'b1;
      RX_COIN:     m_tready = 1'($urandom_range(0, 1));
      RX_PERIODIC: m_tready = (rx_tick % 7) < 3;
      default:     m_tready = ($urandom_range(0, 11) == 0);
    endcase
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result(m_tdata[ddcp_pkg::CODE_W-1:0], m_tuser[0]);
  end

  // Drive one word, with random gaps between bursts
  task automatic send_word(input logic [ddcp_pkg::BYTE_W-1:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ((words_sent / 200) % 3 == 2) ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    board.note_word(b, last);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_word(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Drop valid, drain owed codes, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ddcp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ddcp_pkg::BYTE_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic apply_delims(input logic [ddcp_pkg::BYTE_W-1:0] s,
                              input logic [ddcp_pkg::BYTE_W-1:0] e,
                              input logic [ddcp_pkg::BYTE_W-1:0] c,
                              input logic [ddcp_pkg::BYTE_W-1:0] t);
    write_reg(ddcp_pkg::REG_START_BYTE, s);
    write_reg(ddcp_pkg::REG_END_BYTE, e);
    write_reg(ddcp_pkg::REG_CODE_SEP_BYTE, c);
    write_reg(ddcp_pkg::REG_CODE_END_BYTE, t);
  endtask

  // Any byte that is none of the current delimiters
  function automatic logic [ddcp_pkg::BYTE_W-1:0] junk_byte();
    logic [ddcp_pkg::BYTE_W-1:0] b;
    do b = ddcp_pkg::BYTE_W'($urandom_range(0, 255));
    while (b == board.start_val || b == board.end_val || b == board.sep_val ||
           b == board.term_val);
    return b;
  endfunction

  function automatic logic [ddcp_pkg::BYTE_W-1:0] digit_byte();
    return ddcp_pkg::BYTE_W'(ddcp_pkg::CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  // Bias noise toward delimiters and digits
  function automatic logic [ddcp_pkg::BYTE_W-1:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return board.start_val;
      1:       return board.end_val;
      2:       return board.sep_val;
      3:       return board.term_val;
      4:       return digit_byte();
      default: return ddcp_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Build a well-formed frame: junk, start, junk, separator, digits, terminator, junk, end, junk
  task automatic build_frame(input int n_dig, input int lead, input int mid, input int tail);
    bit nines;
    nines = (n_dig == ddcp_pkg::MAX_DIGITS) && ($urandom_range(0, 1) == 1);
    frame_bytes.delete();
    repeat (lead) frame_bytes.push_back(junk_byte());
    frame_bytes.push_back(board.start_val);
    repeat ($urandom_range(0, 2)) frame_bytes.push_back(junk_byte());
    frame_bytes.push_back(board.sep_val);
    repeat (n_dig) frame_bytes.push_back(nines ? ddcp_pkg::CHAR_NINE : digit_byte());
    frame_bytes.push_back(board.term_val);
    repeat (mid) frame_bytes.push_back(junk_byte());
    frame_bytes.push_back(board.end_val);
    repeat (tail) frame_bytes.push_back(junk_byte());
  endtask

  // Send random frames until the byte budget is spent
  task automatic run_random(input int budget, input long_kind_e long_kind);
    int sent;
    int pick;
    int keep;
    sent = 0;
    if (long_kind == LONG_TAIL) begin
      build_frame($urandom_range(1, 15), 1, 0, $urandom_range(250, 270));
      send_frame();
    end else if (long_kind == LONG_MID) begin
      build_frame($urandom_range(1, 15), 0, $urandom_range(250, 260), 1);
      send_frame();
    end
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        build_frame($urandom_range(0, 3) == 0 ? 15 : $urandom_range(1, 15),
                    $urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0)
          frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = noise_byte();
      end else if (pick < 65) begin
        build_frame($urandom_range(14, 17), 0, 0, 0);
      end else if (pick < 85) begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 10)) frame_bytes.push_back(noise_byte());
      end else begin
        // Cut a frame short, always before its end byte
        build_frame($urandom_range(1, 6), 0, 0, 0);
        keep = $urandom_range(1, frame_bytes.size() - 1);
        while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end
      sent += frame_bytes.size();
      send_frame();
    end
  endtask

  initial begin
    board     = new();
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = ddcp_pkg::REG_START_BYTE;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Short frames on the reset delimiters: good, empty, short, bad digit, no end, out of order
    foreach (directed_frames[k]) begin
      frame_bytes.delete();
      for (int i = 0; i < directed_frames[k].len(); i++)
        frame_bytes.push_back(directed_frames[k][i]);
      send_frame();
    end
    run_random(105, NO_LONG);
    wait_idle();

    apply_delims(8'h00, 8'hFF, 8'h01, 8'hFE);
    run_random(105, LONG_TAIL);
    wait_idle();

    apply_delims(8'hFF, 8'h80, 8'h00, 8'h7F);
    run_random(105, NO_LONG);
    wait_idle();

    // Separator and terminator share one value
    apply_delims("<", ">", "|", "|");
    run_random(105, NO_LONG);
    wait_idle();

    // Terminator equal to end byte, separator is a digit
    apply_delims("{", "}", "5", "}");
    run_random(105, NO_LONG);
    wait_idle();

    apply_delims(ddcp_pkg::BYTE_W'($urandom_range(0, 255)),
                 ddcp_pkg::BYTE_W'($urandom_range(0, 255)),
                 ddcp_pkg::BYTE_W'($urandom_range(0, 255)),
                 ddcp_pkg::BYTE_W'($urandom_range(0, 255)));
    run_random(105, LONG_MID);
    wait_idle();

    apply_delims(ddcp_pkg::START_BYTE_RST, ddcp_pkg::END_BYTE_RST,
                 ddcp_pkg::CODE_SEP_BYTE_RST, ddcp_pkg::CODE_END_BYTE_RST);
    run_random(105, NO_LONG);
    wait_idle();

    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("delimited_decimal_code_parser_core test passed");
    end else begin
      $display("delimited_decimal_code_parser_core test failed");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #1000000;
    $display("delimited_decimal_code_parser_core test failed");
    $finish;
  end

endmodule
